### rtl/core/rasp_pkg.sv
// Package for the IPv6 router advertisement SLAAC parser.
// Payload structs, phase and action codes, constants. No dependencies.
`timescale 1ns / 1ps
package rasp_pkg;

    localparam int unsigned IcmpStart = 54;
    localparam logic [16:0] PosMax    = 17'h1ffff;
    localparam logic [63:0] NsPerSec  = 64'd1000000000;

    typedef enum logic [1:0] {
        PH_WALK  = 2'd0,
        PH_FOUND = 2'd1,
        PH_END   = 2'd2,
        PH_BAD   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RA_NONE     = 2'd0,
        RA_LEARN    = 2'd1,
        RA_WITHDRAW = 2'd2
    } raction_t;

    typedef enum logic [1:0] {
        AA_NONE   = 2'd0,
        AA_ULA    = 2'd1,
        AA_GLOBAL = 2'd2
    } aaction_t;

    localparam logic [1:0] RegMac = 2'd0;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [63:0] now_ns;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  router_action;
        logic [63:0] router_addr_high;
        logic [63:0] router_addr_low;
        logic [63:0] router_expiry;
        logic [1:0]  address_action;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [63:0] address_expiry;
    } out_item_t;

    // frame summary handed from the byte parser to the result stage
    typedef struct packed {
        logic        reject;
        logic        bad;
        logic        found;
        logic [15:0] router_life;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [31:0] valid_life;
        logic [63:0] prefix;
        logic [63:0] now_ns;
    } frame_sum_t;

endpackage

### rtl/core/ipv6_router_advert_slaac_parser.sv
// Top level of the IPv6 router advertisement SLAAC parser.
// Uses rasp_pkg, rasp_front, rasp_queue, rasp_back.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall/in_data carries one frame byte per request,
//   starting at the Ethernet header; frame_last marks the end, now_ns is
//   sampled with it. One result per frame leaves on out_valid/out_stall/out_data.
//   mac_address is written over APB at address 0 (64-bit data, bits 47:0).
//   Throughput: one byte per cycle while in_stall is low. out_valid rises once
//   the last byte has passed the queue (written when that byte is accepted),
//   then the multiply stage, then the output register; out_stall can hold it.
//   in_stall rises only when the two-entry summary queue is full, which
//   happens only if out_stall holds back results across several frames.
//   The last-byte multiply (lifetime by 1e9) has its own register stage.
//   Reset clears the parse state, the router-known flag and the MAC; the
//   output register holds its result while out_stall is high.
module ipv6_router_advert_slaac_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rasp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rasp_pkg::out_item_t  out_data
);

    logic [47:0]          mac_reg;
    logic                 in_take, sum_valid, q_full, q_valid, q_take;
    rasp_pkg::frame_sum_t sum, q_data;

    assign pready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) mac_reg <= '0;
        else if (psel && penable && pwrite && paddr[3:2] == rasp_pkg::RegMac && paddr[1:0] == 2'd0)
            mac_reg <= pwdata[47:0];
    end

    assign prdata = (paddr[3:2] == rasp_pkg::RegMac) ? {16'd0, mac_reg} : 64'd0;

    assign in_stall = q_full;
    assign in_take  = in_valid && !in_stall;

    rasp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .in_item   (in_data),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    rasp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (sum_valid),
        .wr_data  (sum),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_data  (q_data)
    );

    rasp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mac       (mac_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_take    (q_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_data)
    );

    // a held result must not change under stall
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no summary is written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sum_valid && q_full))
        else $error("summary queue overflow");

    // a rejected frame never reports a router or address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == rasp_pkg::ST_SHORT |->
        out_data.router_action == rasp_pkg::RA_NONE &&
        out_data.address_action == rasp_pkg::AA_NONE)
        else $error("rejected frame carried actions");

endmodule

### rtl/core/rasp_front.sv
// Front part: walks frame bytes, captures header fields and the option list.
// Emits one frame summary at the last byte. Depends on rasp_pkg.
`timescale 1ns / 1ps
module rasp_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_take,
    input  rasp_pkg::in_item_t    in_item,
    output logic                  sum_valid,
    output rasp_pkg::frame_sum_t  sum
);

    logic [16:0]      pos_reg;
    logic [15:0]      plen_reg;
    logic [15:0]      rlife_reg;
    logic [63:0]      src0_reg, src1_reg;
    logic [16:0]      ooff_reg;
    logic [10:0]      obytes_reg;
    logic [31:0]      ohdr_reg;
    logic [31:0]      vlife_reg;
    logic [63:0]      pfx_reg;
    rasp_pkg::phase_t phase_reg;

    logic [7:0]       b;
    logic [15:0]      plen_next;
    logic [15:0]      rlife_next;
    logic [63:0]      src0_next, src1_next;
    logic [16:0]      ooff_next;
    logic [10:0]      obytes_next;
    logic [31:0]      ohdr_next;
    logic [31:0]      vlife_next;
    logic [63:0]      pfx_next;
    rasp_pkg::phase_t phase_next;
    logic [16:0]      r, rel;
    logic [17:0]      flen;

    assign b = in_item.frame_byte;

    // per-byte field capture and option walk
    always_comb
    begin
        plen_next   = plen_reg;
        rlife_next  = rlife_reg;
        src0_next   = src0_reg;
        src1_next   = src1_reg;
        ooff_next   = ooff_reg;
        obytes_next = obytes_reg;
        ohdr_next   = ohdr_reg;
        vlife_next  = vlife_reg;
        pfx_next    = pfx_reg;
        phase_next  = phase_reg;
        r   = pos_reg - 17'(rasp_pkg::IcmpStart);
        rel = r - ooff_reg;
        if (pos_reg == 17'd18) plen_next = {b, 8'd0};
        else if (pos_reg == 17'd19) plen_next = {plen_reg[15:8], b};
        if (pos_reg >= 17'd22 && pos_reg <= 17'd29) src0_next = {src0_reg[55:0], b};
        else if (pos_reg >= 17'd30 && pos_reg <= 17'd37) src1_next = {src1_reg[55:0], b};
        if (pos_reg == 17'(rasp_pkg::IcmpStart + 6)) rlife_next = {b, 8'd0};
        else if (pos_reg == 17'(rasp_pkg::IcmpStart + 7)) rlife_next = {rlife_reg[15:8], b};
        if (pos_reg >= 17'(rasp_pkg::IcmpStart) && r >= ooff_reg)
        begin
            if (phase_reg == rasp_pkg::PH_FOUND)
            begin
                if (rel >= 17'd4 && rel <= 17'd7) vlife_next = {vlife_reg[23:0], b};
                if (rel >= 17'd16 && rel <= 17'd23) pfx_next = {pfx_reg[55:0], b};
            end
            else if (phase_reg == rasp_pkg::PH_WALK && r < {1'b0, plen_reg})
            begin
                if (rel == 17'd0)
                begin
                    if ({1'b0, ooff_reg} + 18'd2 > {2'b0, plen_reg})
                        phase_next = rasp_pkg::PH_END;
                    else
                        ohdr_next = {24'd0, b};
                end
                else if (rel <= 17'd3)
                begin
                    ohdr_next = {ohdr_reg[23:0], b};
                    if (rel == 17'd1)
                    begin
                        obytes_next = {b, 3'd0};
                        if (b == 8'd0 ||
                            {6'd0, b, 3'd0} > 17'(plen_reg) - ooff_reg)
                            phase_next = rasp_pkg::PH_BAD;
                    end
                    else if (rel == 17'd3)
                    begin
                        if (ohdr_reg[23:16] == 8'd3 && obytes_reg == 11'd32 &&
                            ohdr_reg[7:0] == 8'd64 && b[6])
                            phase_next = rasp_pkg::PH_FOUND;
                    end
                end
                else if (rel == 17'(obytes_reg) - 17'd1)
                    ooff_next = ooff_reg + 17'(obytes_reg);
            end
        end
    end

    // length checks and frame summary at the last byte
    always_comb
    begin
        flen = {1'b0, pos_reg} + 18'd1;
        sum.reject = flen < 18'(rasp_pkg::IcmpStart + 16) || plen_next < 16'd16 ||
                     {2'b0, plen_next} > flen - 18'(rasp_pkg::IcmpStart);
        sum.bad         = phase_next == rasp_pkg::PH_BAD;
        sum.found       = phase_next == rasp_pkg::PH_FOUND;
        sum.router_life = rlife_next;
        sum.src_high    = src0_next;
        sum.src_low     = src1_next;
        sum.valid_life  = vlife_next;
        sum.prefix      = pfx_next;
        sum.now_ns      = in_item.now_ns;
    end

    assign sum_valid = in_take && in_item.frame_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            plen_reg   <= '0;
            rlife_reg  <= '0;
            ooff_reg   <= 17'd16;
            obytes_reg <= '0;
            ohdr_reg   <= '0;
            vlife_reg  <= '0;
            pfx_reg    <= '0;
            phase_reg  <= rasp_pkg::PH_WALK;
        end
        else if (in_take)
        begin
            if (in_item.frame_last)
            begin
                pos_reg    <= '0;
                plen_reg   <= '0;
                rlife_reg  <= '0;
                ooff_reg   <= 17'd16;
                obytes_reg <= '0;
                ohdr_reg   <= '0;
                vlife_reg  <= '0;
                pfx_reg    <= '0;
                phase_reg  <= rasp_pkg::PH_WALK;
            end
            else
            begin
                if (pos_reg != rasp_pkg::PosMax) pos_reg <= pos_reg + 17'd1;
                plen_reg   <= plen_next;
                rlife_reg  <= rlife_next;
                ooff_reg   <= ooff_next;
                obytes_reg <= obytes_next;
                ohdr_reg   <= ohdr_next;
                vlife_reg  <= vlife_next;
                pfx_reg    <= pfx_next;
                phase_reg  <= phase_next;
            end
        end
    end

    // source address store
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            src0_reg <= src0_next;
            src1_reg <= src1_next;
        end
    end

endmodule

### rtl/core/rasp_queue.sv
// Two-entry queue of frame summaries between the parser and the result stage.
// Depends on rasp_pkg.
`timescale 1ns / 1ps
module rasp_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  rasp_pkg::frame_sum_t  wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  logic                  rd_en,
    output rasp_pkg::frame_sum_t  rd_data
);

    rasp_pkg::frame_sum_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

endmodule

### rtl/core/rasp_back.sv
// Back part: router tracking, expiry arithmetic, SLAAC address, output register.
// Two stages: product register then sum/saturate. Depends on rasp_pkg.
`timescale 1ns / 1ps
module rasp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [47:0]           mac,
    input  logic                  q_valid,
    input  rasp_pkg::frame_sum_t  q_data,
    output logic                  q_take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rasp_pkg::out_item_t   out_item
);

    logic                 s1_valid_reg;
    rasp_pkg::frame_sum_t s1_reg;
    logic [63:0]          rspan_reg, aspan_reg;
    logic                 ovalid_reg;
    rasp_pkg::out_item_t  out_reg;
    logic                 known_reg;

    logic                 s1_go, s2_go;
    rasp_pkg::out_item_t  res;
    logic [64:0]          rsum, asum;
    logic [7:0]           top;
    logic                 glob, ula;

    assign s2_go  = s1_valid_reg && (!ovalid_reg || !out_stall);
    assign s1_go  = !s1_valid_reg || s2_go;
    assign q_take = q_valid && s1_go;

    // stage 1: lifetimes times one billion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else if (s1_go) s1_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            s1_reg    <= q_data;
            rspan_reg <= 64'(q_data.router_life) * rasp_pkg::NsPerSec;
            aspan_reg <= 64'(q_data.valid_life) * rasp_pkg::NsPerSec;
        end
    end

    // stage 2: result fields
    always_comb
    begin
        res  = '0;
        rsum = {1'b0, s1_reg.now_ns} + {1'b0, rspan_reg};
        asum = {1'b0, s1_reg.now_ns} + {1'b0, aspan_reg};
        top  = s1_reg.prefix[63:56];
        glob = (top & 8'he0) == 8'h20;
        ula  = (top & 8'hfe) == 8'hfc;
        if (s1_reg.reject)
            res.status = rasp_pkg::ST_SHORT;
        else
        begin
            if (s1_reg.router_life != 16'd0)
            begin
                res.router_action    = rasp_pkg::RA_LEARN;
                res.router_addr_high = s1_reg.src_high;
                res.router_addr_low  = s1_reg.src_low;
                res.router_expiry    = rsum[64] ? '1 : rsum[63:0];
            end
            else if (known_reg)
                res.router_action = rasp_pkg::RA_WITHDRAW;
            if (s1_reg.bad)
                res.status = rasp_pkg::ST_BAD;
            else if (s1_reg.found && s1_reg.valid_life != 32'd0 && (glob || ula))
            begin
                res.address_action = glob ? rasp_pkg::AA_GLOBAL : rasp_pkg::AA_ULA;
                res.address_high   = s1_reg.prefix;
                res.address_low    = {mac[47:40] ^ 8'h02, mac[39:24], 16'hfffe, mac[23:0]};
                res.address_expiry = asum[64] ? '1 : asum[63:0];
            end
        end
    end

    // output register and router flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            known_reg  <= 1'b0;
        end
        else
        begin
            if (s2_go)
            begin
                ovalid_reg <= 1'b1;
                if (!s1_reg.reject) known_reg <= s1_reg.router_life != 16'd0;
            end
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go) out_reg <= res;
    end

    assign out_valid = ovalid_reg;
    assign out_item  = out_reg;

endmodule
